FILE: hw/rtl/ddo_pkg.sv
`default_nettype none
package ddo_pkg;

  // field widths
  localparam int RPM_W   = 16;
  localparam int DT_W    = 22;
  localparam int POS_W   = 40;
  localparam int ANG_W   = 32;
  localparam int VEL_W   = 32;
  localparam int DIAM_W  = 21;
  localparam int TRACK_W = 22;

  // configuration port
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK      = 1'b1;
  localparam logic [DIAM_W-1:0]    DIAM_RESET     = 21'd100000;
  localparam logic [TRACK_W-1:0]   TRACK_RESET    = 22'd300000;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // arithmetic constants
  localparam logic [25:0] PI24      = 26'd52707179;     // pi in Q24
  localparam logic [47:0] VEL_DIV   = 48'd32212254720;  // 1920 * 2^24
  localparam logic [47:0] USEC_DIV  = 48'd1000000;
  localparam logic [23:0] HEAD_K    = 24'd15000000;
  localparam logic [11:0] W_K       = 12'd3125;
  localparam logic [63:0] W_QLIM    = 64'd11529215046068; // 2^55 / 3125

  // arctangent table, full turn = 2^32
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ddo_in_if.sv
`default_nettype none
interface ddo_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddo_pkg::RPM_W-1:0]   left_rpm;
  logic signed [ddo_pkg::RPM_W-1:0]   right_rpm;
  logic        [ddo_pkg::DT_W-1:0]    elapsed_us;

  modport source (output valid, left_rpm, right_rpm, elapsed_us, input ready);
  modport sink   (input valid, left_rpm, right_rpm, elapsed_us, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ddo_out_if.sv
`default_nettype none
interface ddo_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ddo_pkg::POS_W-1:0]   pos_x_um;
  logic signed [ddo_pkg::POS_W-1:0]   pos_y_um;
  logic        [ddo_pkg::ANG_W-1:0]   heading_angle;
  logic signed [ddo_pkg::VEL_W-1:0]   vel_x_um_s;
  logic signed [ddo_pkg::VEL_W-1:0]   vel_y_um_s;
  logic signed [ddo_pkg::VEL_W-1:0]   ang_vel_urad_s;

  modport source (output valid, pos_x_um, pos_y_um, heading_angle, vel_x_um_s,
                  vel_y_um_s, ang_vel_urad_s, input ready);
  modport sink   (input valid, pos_x_um, pos_y_um, heading_angle, vel_x_um_s,
                  vel_y_um_s, ang_vel_urad_s, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/diff_drive_odometry.sv
`default_nettype none
// Differential-drive odometry: each input word (two wheel speeds and the
// elapsed time) yields one output word with the new pose, the velocity along
// the old heading and the angular velocity. One word is in work at a time: a
// CORDIC, then a chain of bit-serial multiplies and restoring divides on a
// shared multiplier and divider. Zero track width skips the turn rate and
// heading step. The next word is taken while the finished result still waits
// in the output register.
module diff_drive_odometry (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ddo_in_if.sink                             in_ch,
  ddo_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ddo_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_COR  = 5'd1;
  localparam logic [4:0] S_VM1  = 5'd2;
  localparam logic [4:0] S_VM2  = 5'd3;
  localparam logic [4:0] S_VD   = 5'd4;
  localparam logic [4:0] S_CXM  = 5'd5;
  localparam logic [4:0] S_CYM  = 5'd6;
  localparam logic [4:0] S_PD   = 5'd7;
  localparam logic [4:0] S_WM   = 5'd8;
  localparam logic [4:0] S_WD   = 5'd9;
  localparam logic [4:0] S_WQ   = 5'd10;
  localparam logic [4:0] S_WR   = 5'd11;
  localparam logic [4:0] S_WD2  = 5'd12;
  localparam logic [4:0] S_HK   = 5'd13;
  localparam logic [4:0] S_HM   = 5'd14;
  localparam logic [4:0] S_HD   = 5'd15;
  localparam logic [4:0] S_XM   = 5'd16;
  localparam logic [4:0] S_XD   = 5'd17;
  localparam logic [4:0] S_YM   = 5'd18;
  localparam logic [4:0] S_YD   = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  localparam logic [6:0] DIV_LEN  = 7'd64;
  localparam logic [6:0] HEAD_LEN = 7'd89;  // 64 integer + 25 fraction bits

  // round a Q30 product and saturate to 32 bits
  function automatic logic [31:0] q30_sat(input logic [63:0] prod, input logic neg);
    logic [34:0] m;
    logic [31:0] r;
    m = {1'b0, prod[63:30]} + 35'(prod[29]);
    if (neg) begin
      r = (m > 35'h080000000) ? 32'h80000000 : 32'(-m);
    end else begin
      r = (m > 35'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
    return r;
  endfunction

  // signed add of a magnitude onto a position, saturating to 40 bits
  function automatic logic [39:0] pos_add(input logic [39:0] pos, input logic [34:0] m,
                                          input logic neg);
    logic [41:0] sum;
    logic [39:0] r;
    sum = neg ? ({{2{pos[39]}}, pos} - 42'(m)) : ({{2{pos[39]}}, pos} + 42'(m));
    if (sum[41:39] == 3'b000 || sum[41:39] == 3'b111) begin
      r = sum[39:0];
    end else begin
      r = sum[41] ? 40'h8000000000 : 40'h7FFFFFFFFF;
    end
    return r;
  endfunction

  // configuration
  logic [ddo_pkg::DIAM_W-1:0]  diam_r;
  logic [ddo_pkg::TRACK_W-1:0] track_r;

  // pose
  logic [39:0] pose_x_r, pose_y_r;
  logic [31:0] head_r;

  // sequencer
  logic [4:0] state_r;
  logic       phase_r;

  // latched word
  logic [15:0] smag_r;
  logic        vel_neg_r;
  logic [16:0] pmag_r;
  logic        psign_r;
  logic [21:0] dt_r;

  // intermediates
  logic [31:0] vel_mag_r;
  logic [37:0] pd_r;
  logic [43:0] wq_r;
  logic [23:0] rm_r;
  logic [63:0] tmp_r;
  logic [31:0] vx_r, vy_r, w_r, dh_r;

  // CORDIC
  logic signed [33:0] cor_x_r, cor_y_r, cor_z_r;
  logic [ddo_pkg::ITER_W-1:0] cor_iter_r;
  logic        flip_r;
  logic        cos_neg_r, sin_neg_r;
  logic [31:0] cos_mag_r, sin_mag_r;

  // output register
  logic        out_valid_r;
  logic [39:0] o_x_r, o_y_r;
  logic [31:0] o_h_r, o_vx_r, o_vy_r, o_w_r;

  // bit-serial multiplier
  logic [63:0] mul_a_r, mul_acc_r;
  logic [31:0] mul_b_r;
  logic        mul_start;
  logic [63:0] mul_a_in;
  logic [31:0] mul_b_in;
  logic        mul_busy;

  // restoring divider
  logic [63:0] div_n_r, div_q_r;
  logic [47:0] div_d_r, div_rem_r;
  logic [6:0]  div_cnt_r;
  logic        div_start;
  logic [63:0] div_n_in;
  logic [47:0] div_d_in;
  logic [6:0]  div_len_in;
  logic        div_busy;
  logic [48:0] div_try, div_sub;
  logic        div_ge, div_rnd;

  // misc
  logic [23:0] track3;
  logic        accept;
  logic        op_done;
  logic [31:0] vx_mag, vy_mag;
  logic [55:0] v24;
  logic [32:0] wm, wlim;

  // input split
  logic signed [16:0] s17;
  logic signed [17:0] sum18;
  logic [31:0] head_q;
  logic [31:0] cor_a;

  // CORDIC step
  logic signed [33:0] cor_dx, cor_dy;
  logic [33:0] atan_ext;
  logic signed [33:0] cval, sval;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign mul_busy    = |mul_b_r;
  assign div_busy    = |div_cnt_r;
  assign track3      = {2'b00, track_r} + {1'b0, track_r, 1'b0};
  assign op_done     = phase_r && !mul_busy && !div_busy;

  assign s17    = $signed({in_ch.left_rpm[15], in_ch.left_rpm})
                - $signed({in_ch.right_rpm[15], in_ch.right_rpm});
  assign sum18  = $signed({{2{in_ch.left_rpm[15]}}, in_ch.left_rpm})
                + $signed({{2{in_ch.right_rpm[15]}}, in_ch.right_rpm});
  assign head_q = head_r + 32'h40000000;
  assign cor_a  = head_q[31] ? {~head_r[31], head_r[30:0]} : head_r;

  assign cor_dx   = cor_y_r >>> cor_iter_r;
  assign cor_dy   = cor_x_r >>> cor_iter_r;
  assign atan_ext = {2'b00, ddo_pkg::atan_val(5'(cor_iter_r))};
  assign cval     = flip_r ? -cor_x_r : cor_x_r;
  assign sval     = flip_r ? -cor_y_r : cor_y_r;

  assign vx_mag = vx_r[31] ? -vx_r : vx_r;
  assign vy_mag = vy_r[31] ? -vy_r : vy_r;

  assign v24  = tmp_r[55:0] + 56'(div_q_r[11:0]);
  assign wm   = 33'(v24[55:24]) + 33'(v24[23]);
  assign wlim = psign_r ? 33'h080000000 : 33'h07FFFFFFF;

  assign div_try = {div_rem_r, div_n_r[63]};
  assign div_sub = div_try - {1'b0, div_d_r};
  assign div_ge  = (div_try >= {1'b0, div_d_r});
  assign div_rnd = ({div_rem_r, 1'b0} >= {1'b0, div_d_r});

  // operand select for the shared units
  always_comb begin
    mul_start  = 1'b0;
    mul_a_in   = '0;
    mul_b_in   = '0;
    div_start  = 1'b0;
    div_n_in   = mul_acc_r;
    div_d_in   = ddo_pkg::USEC_DIV;
    div_len_in = DIV_LEN;
    unique case (state_r)
      S_VM1: begin mul_a_in = 64'(smag_r);    mul_b_in = 32'(diam_r); end
      S_VM2: begin mul_a_in = mul_acc_r;      mul_b_in = 32'(ddo_pkg::PI24); end
      S_CXM: begin mul_a_in = 64'(vel_mag_r); mul_b_in = cos_mag_r; end
      S_CYM: begin mul_a_in = 64'(vel_mag_r); mul_b_in = sin_mag_r; end
      S_PD:  begin mul_a_in = 64'(pmag_r);    mul_b_in = 32'(diam_r); end
      S_WM:  begin mul_a_in = 64'(pd_r);      mul_b_in = 32'(ddo_pkg::PI24); end
      S_WQ:  begin mul_a_in = 64'(wq_r);      mul_b_in = 32'(ddo_pkg::W_K); end
      S_WR:  begin mul_a_in = 64'(rm_r);      mul_b_in = 32'(ddo_pkg::W_K); end
      S_HK:  begin mul_a_in = 64'(ddo_pkg::HEAD_K); mul_b_in = 32'(track_r); end
      S_HM:  begin mul_a_in = 64'(pd_r);      mul_b_in = 32'(dt_r); end
      S_XM:  begin mul_a_in = 64'(vx_mag);    mul_b_in = 32'(dt_r); end
      S_YM:  begin mul_a_in = 64'(vy_mag);    mul_b_in = 32'(dt_r); end
      S_VD:  div_d_in = ddo_pkg::VEL_DIV;
      S_WD:  div_d_in = 48'(track3);
      S_WD2: div_d_in = 48'(track3);
      S_HD:  begin div_d_in = tmp_r[47:0]; div_len_in = HEAD_LEN; end
      default: ;
    endcase
    if (!phase_r) begin
      unique case (state_r)
        S_VM1, S_VM2, S_CXM, S_CYM, S_PD, S_WM, S_WQ, S_WR, S_HK, S_HM,
        S_XM, S_YM: mul_start = 1'b1;
        S_VD, S_WD, S_WD2, S_HD, S_XD, S_YD: div_start = 1'b1;
        default: ;
      endcase
    end
  end

  // multiplier: one bit of b per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_b_r <= '0;
    end else if (mul_start) begin
      mul_a_r   <= mul_a_in;
      mul_b_r   <= mul_b_in;
      mul_acc_r <= '0;
    end else if (mul_busy) begin
      if (mul_b_r[0]) mul_acc_r <= mul_acc_r + mul_a_r;
      mul_a_r <= {mul_a_r[62:0], 1'b0};
      mul_b_r <= {1'b0, mul_b_r[31:1]};
    end
  end

  // divider: one quotient bit per cycle, zeros shift in past the numerator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_n_r   <= div_n_in;
      div_d_r   <= div_d_in;
      div_rem_r <= '0;
      div_q_r   <= '0;
      div_cnt_r <= div_len_in;
    end else if (div_busy) begin
      div_rem_r <= div_ge ? div_sub[47:0] : div_try[47:0];
      div_n_r   <= {div_n_r[62:0], 1'b0};
      div_q_r   <= {div_q_r[62:0], div_ge};
      div_cnt_r <= div_cnt_r - 7'd1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r  <= ddo_pkg::DIAM_RESET;
      track_r <= ddo_pkg::TRACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddo_pkg::REG_WHEEL_DIAM: diam_r  <= cfg_wdata[ddo_pkg::DIAM_W-1:0];
        ddo_pkg::REG_TRACK:      track_r <= cfg_wdata[ddo_pkg::TRACK_W-1:0];
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      head_r      <= '0;
    end else begin
      // a waiting word leaves; a reload in S_OUT keeps the flag set instead
      if (out_valid_r && out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      if (mul_start || div_start) phase_r <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            smag_r     <= s17[16] ? 16'(-s17) : s17[15:0];
            vel_neg_r  <= s17[16];
            pmag_r     <= sum18[17] ? 17'(-sum18) : sum18[16:0];
            psign_r    <= !sum18[17] && (sum18 != 18'sd0);
            dt_r       <= in_ch.elapsed_us;
            flip_r     <= head_q[31];
            cor_x_r    <= ddo_pkg::CORDIC_GAIN;
            cor_y_r    <= '0;
            cor_z_r    <= $signed({{2{cor_a[31]}}, cor_a});
            cor_iter_r <= '0;
            state_r    <= S_COR;
          end
        end
        S_COR: begin
          if (cor_iter_r == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_STEPS)) begin
            cos_neg_r <= cval[33];
            cos_mag_r <= cval[33] ? 32'(-cval) : cval[31:0];
            sin_neg_r <= sval[33];
            sin_mag_r <= sval[33] ? 32'(-sval) : sval[31:0];
            state_r   <= S_VM1;
          end else begin
            if (!cor_z_r[33]) begin
              cor_x_r <= cor_x_r - cor_dx;
              cor_y_r <= cor_y_r + cor_dy;
              cor_z_r <= cor_z_r - $signed(atan_ext);
            end else begin
              cor_x_r <= cor_x_r + cor_dx;
              cor_y_r <= cor_y_r - cor_dy;
              cor_z_r <= cor_z_r + $signed(atan_ext);
            end
            cor_iter_r <= cor_iter_r + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            o_x_r       <= pose_x_r;
            o_y_r       <= pose_y_r;
            o_h_r       <= head_r;
            o_vx_r      <= vx_r;
            o_vy_r      <= vy_r;
            o_w_r       <= w_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          if (op_done) begin
            phase_r <= 1'b0;
            unique case (state_r)
              S_VM1: state_r <= S_VM2;
              S_VM2: state_r <= S_VD;
              S_VD: begin
                vel_mag_r <= div_q_r[31:0] + 32'(div_rnd);
                state_r   <= S_CXM;
              end
              S_CXM: begin
                vx_r    <= q30_sat(mul_acc_r, vel_neg_r ^ cos_neg_r);
                state_r <= S_CYM;
              end
              S_CYM: begin
                vy_r    <= q30_sat(mul_acc_r, vel_neg_r ^ sin_neg_r);
                state_r <= S_PD;
              end
              S_PD: begin
                pd_r <= mul_acc_r[37:0];
                if (track_r == '0) begin
                  // no track width: no turn
                  w_r     <= '0;
                  dh_r    <= '0;
                  state_r <= S_XM;
                end else begin
                  state_r <= S_WM;
                end
              end
              S_WM: state_r <= S_WD;
              S_WD: begin
                wq_r <= div_q_r[43:0];
                rm_r <= div_rem_r[23:0];
                if (div_q_r > ddo_pkg::W_QLIM) begin
                  w_r     <= psign_r ? 32'h80000000 : 32'h7FFFFFFF;
                  state_r <= S_HK;
                end else begin
                  state_r <= S_WQ;
                end
              end
              S_WQ: begin
                tmp_r   <= mul_acc_r;
                state_r <= S_WR;
              end
              S_WR: state_r <= S_WD2;
              S_WD2: begin
                w_r     <= psign_r ? 32'(-(wm > wlim ? wlim : wm))
                                   : 32'(wm > wlim ? wlim : wm);
                state_r <= S_HK;
              end
              S_HK: begin
                tmp_r   <= mul_acc_r;
                state_r <= S_HM;
              end
              S_HM: state_r <= S_HD;
              S_HD: begin
                dh_r    <= psign_r ? -div_q_r[31:0] : div_q_r[31:0];
                state_r <= S_XM;
              end
              S_XM: state_r <= S_XD;
              S_XD: begin
                pose_x_r <= pos_add(pose_x_r, div_q_r[34:0] + 35'(div_rnd), vx_r[31]);
                state_r  <= S_YM;
              end
              S_YM: state_r <= S_YD;
              S_YD: begin
                pose_y_r <= pos_add(pose_y_r, div_q_r[34:0] + 35'(div_rnd), vy_r[31]);
                head_r   <= head_r + dh_r;
                state_r  <= S_OUT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // result word
  assign out_ch.valid          = out_valid_r;
  assign out_ch.pos_x_um       = $signed(o_x_r);
  assign out_ch.pos_y_um       = $signed(o_y_r);
  assign out_ch.heading_angle  = o_h_r;
  assign out_ch.vel_x_um_s     = $signed(o_vx_r);
  assign out_ch.vel_y_um_s     = $signed(o_vy_r);
  assign out_ch.ang_vel_urad_s = $signed(o_w_r);

endmodule
`default_nettype wire

FILE: verif/diff_drive_odometry_chk.sv
`timescale 1ns / 100ps
`default_nettype none
module diff_drive_odometry_chk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ddo_in_if                                  in_ch,
  ddo_out_if                                 out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ddo_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                 errors,
  output int                                 pending
);

  typedef struct packed {
    logic signed [ddo_pkg::POS_W-1:0] pos_x;
    logic signed [ddo_pkg::POS_W-1:0] pos_y;
    logic        [ddo_pkg::ANG_W-1:0] heading;
    logic signed [ddo_pkg::VEL_W-1:0] vel_x;
    logic signed [ddo_pkg::VEL_W-1:0] vel_y;
    logic signed [ddo_pkg::VEL_W-1:0] ang_vel;
  } odo_word_t;

  localparam longint TWO39   = 64'sd549755813888;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // arctangent per micro-rotation, full turn = 2^32
  localparam logic [31:0] ATAN_LUT [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  logic [ddo_pkg::DIAM_W-1:0]  diam_um;
  logic [ddo_pkg::TRACK_W-1:0] track_um;
  longint                      pose_x, pose_y;
  logic [31:0]                 pose_hdg;
  odo_word_t                   pose_q[$];

  function automatic longint unsigned abs64(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // n / d, half away from zero
  function automatic longint unsigned div_round(input longint unsigned n,
                                                input longint unsigned d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (r >= d - r) q++;
    return q;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint signed_scale(input longint v, input longint k,
                                          input longint unsigned dv);
    longint r;
    r = div_round(abs64(v) * abs64(k), dv);
    return ((v < 0) != (k < 0)) ? -r : r;
  endfunction

  // cos/sin of the heading in Q30
  function automatic void heading_trig(input logic [31:0] ang, output longint c,
                                       output longint s);
    logic [31:0] a, probe;
    logic        flip;
    longint      x, y, z, t, dx, dy;
    a = ang;
    probe = a + 32'h40000000;
    flip = probe[31];
    if (flip) a = a - 32'h80000000;
    z = longint'($signed(a));
    x = longint'(ddo_pkg::CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < ddo_pkg::CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        t = x - dx; y = y + dy; z = z - longint'({32'b0, ATAN_LUT[i]});
      end else begin
        t = x + dx; y = y - dy; z = z + longint'({32'b0, ATAN_LUT[i]});
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // one Euler step of the pose
  function automatic odo_word_t odo_step(input logic signed [15:0] l_rpm,
                                         input logic signed [15:0] r_rpm,
                                         input logic [21:0] dt_us);
    longint          sd, pd, vel, cs, sn, vx, vy, w, wm;
    longint unsigned d, t, dt, m, n, e, q, rm, lim, nn, mm, qq, rr, fr;
    logic [31:0]     dh;
    odo_word_t       o;
    d = diam_um;
    t = track_um;
    dt = dt_us;
    sd = longint'(l_rpm) - longint'(r_rpm);
    pd = -(longint'(l_rpm) + longint'(r_rpm));
    w = 0;
    dh = '0;
    m = div_round(abs64(sd) * d * 52707179, 64'd1920 << 24);
    vel = sd < 0 ? -longint'(m) : longint'(m);
    if (t != 0) begin
      n = abs64(pd) * d * 52707179;
      e = 3 * t;
      q = n / e;
      rm = n % e;
      lim = pd < 0 ? 64'h80000000 : 64'h7FFFFFFF;
      if (q > (64'd1 << 55) / 3125) wm = lim;
      else begin
        m = div_round(q * 3125 + (rm * 3125) / e, 64'd1 << 24);
        wm = m > lim ? lim : m;
      end
      w = pd < 0 ? -wm : wm;
      // heading step as 25 fraction bits of a long division
      nn = abs64(pd) * d * dt;
      mm = 64'd15000000 * t;
      qq = nn / mm;
      rr = nn % mm;
      fr = 0;
      for (int k = 0; k < 25; k++) begin
        rr = rr << 1; fr = fr << 1;
        if (rr >= mm) begin
          rr = rr - mm; fr = fr | 1;
        end
      end
      dh = 32'((qq << 25) + fr);
      if (pd < 0) dh = 32'(0) - dh;
    end
    heading_trig(pose_hdg, cs, sn);
    vx = clamp(signed_scale(vel, cs, 64'd1 << 30), I32_MIN, I32_MAX);
    vy = clamp(signed_scale(vel, sn, 64'd1 << 30), I32_MIN, I32_MAX);
    pose_x = clamp(pose_x + signed_scale(vx, dt, 1000000), -TWO39, TWO39 - 1);
    pose_y = clamp(pose_y + signed_scale(vy, dt, 1000000), -TWO39, TWO39 - 1);
    pose_hdg = pose_hdg + dh;
    o.pos_x = pose_x[39:0];
    o.pos_y = pose_y[39:0];
    o.heading = pose_hdg;
    o.vel_x = vx[31:0];
    o.vel_y = vy[31:0];
    o.ang_vel = w[31:0];
    return o;
  endfunction

  function automatic void report_field(input string name, input longint unsigned exp_v,
                                       input longint unsigned act_v);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
  endfunction

  // watch the channels, predict and compare
  always @(posedge clk) begin
    odo_word_t e;
    if (!rst_n) begin
      diam_um  <= ddo_pkg::DIAM_RESET;
      track_um <= ddo_pkg::TRACK_RESET;
      pose_x = 0;
      pose_y = 0;
      pose_hdg = '0;
      pose_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ddo_pkg::REG_WHEEL_DIAM) diam_um <= cfg_wdata[ddo_pkg::DIAM_W-1:0];
        else if (cfg_index == ddo_pkg::REG_TRACK)
          track_um <= cfg_wdata[ddo_pkg::TRACK_W-1:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pose_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t unexpected output word", $realtime);
        end else begin
          e = pose_q.pop_front();
          if (out_ch.pos_x_um !== e.pos_x) report_field("pos_x_um", e.pos_x, out_ch.pos_x_um);
          if (out_ch.pos_y_um !== e.pos_y) report_field("pos_y_um", e.pos_y, out_ch.pos_y_um);
          if (out_ch.heading_angle !== e.heading)
            report_field("heading_angle", e.heading, out_ch.heading_angle);
          if (out_ch.vel_x_um_s !== e.vel_x)
            report_field("vel_x_um_s", e.vel_x, out_ch.vel_x_um_s);
          if (out_ch.vel_y_um_s !== e.vel_y)
            report_field("vel_y_um_s", e.vel_y, out_ch.vel_y_um_s);
          if (out_ch.ang_vel_urad_s !== e.ang_vel)
            report_field("ang_vel_urad_s", e.ang_vel, out_ch.ang_vel_urad_s);
        end
      end
      if (in_ch.valid && in_ch.ready)
        pose_q.push_back(odo_step(in_ch.left_rpm, in_ch.right_rpm, in_ch.elapsed_us));
    end
    pending <= pose_q.size();
  end
endmodule
`default_nettype wire

FILE: verif/diff_drive_odometry_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module diff_drive_odometry_tb;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ddo_pkg::CFG_W-1:0]     cfg_wdata;
  int                            errors, pending;
  int                            stall_left;
  bit                            calm;

  ddo_in_if  in_ch();
  ddo_out_if out_ch();

  diff_drive_odometry dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  diff_drive_odometry_chk chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) stall_left <= pick_gap();
    end
  end

  task automatic send_word(input logic [15:0] l, input logic [15:0] r, input logic [21:0] dt);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.left_rpm   <= l;
    in_ch.right_rpm  <= r;
    in_ch.elapsed_us <= dt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // one write cycle; the caller drops the enable after its last write
  task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ddo_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [ddo_pkg::CFG_W-1:0] diam,
                              input logic [ddo_pkg::CFG_W-1:0] track);
    settle();
    write_reg(ddo_pkg::REG_WHEEL_DIAM, diam);
    write_reg(ddo_pkg::REG_TRACK, track);
    cfg_we <= 1'b0;
  endtask

  // random update: full-range, near-straight or slow
  task automatic random_word();
    logic [15:0] l, r;
    logic [21:0] dt;
    int          k;
    k = $urandom_range(0, 99);
    l = 16'($urandom);
    r = 16'($urandom);
    if (k >= 55 && k < 80) r = -l + 16'($urandom_range(0, 64)) - 16'd32;
    else if (k >= 80) begin
      l = 16'($signed($urandom_range(0, 800)) - 400);
      r = 16'($signed($urandom_range(0, 800)) - 400);
    end
    k = $urandom_range(0, 9);
    if (k < 4) dt = 22'($urandom);
    else if (k < 8) dt = 22'($urandom_range(0, 100000));
    else if (k == 8) dt = '0;
    else dt = '1;
    send_word(l, r, dt);
  endtask

  task automatic random_phase(input int n);
    calm = ($urandom_range(0, 3) == 0);
    repeat (n) random_word();
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.left_rpm   <= '0;
    in_ch.right_rpm  <= '0;
    in_ch.elapsed_us <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= ddo_pkg::REG_WHEEL_DIAM;
    cfg_wdata        <= '0;
    calm             = 1'b0;
    rst_n            <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle, straight, spin, extremes, zero time
    send_word(16'd0, 16'd0, 22'd0);
    send_word(16'd1600, -16'd1600, 22'd1000000);
    send_word(16'd1600, 16'd1600, 22'd500000);
    send_word(16'h7FFF, 16'h8000, 22'h3FFFFF);
    send_word(16'h8000, 16'h7FFF, 22'h3FFFFF);
    send_word(16'h7FFF, 16'h7FFF, 22'h3FFFFF);
    send_word(16'h8000, 16'h8000, 22'h3FFFFF);
    send_word(16'h8000, 16'h8000, 22'd0);
    send_word(16'hFFFF, 16'h0001, 22'd1);
    send_word(16'd3200, 16'd0, 22'd2000000);
    send_word(16'd0, 16'd3200, 22'd2000000);
    set_geometry(22'd1000, 22'd1000);
    send_word(16'h7FFF, 16'h8000, 22'h3FFFFF);
    send_word(16'h8000, 16'h8000, 22'h3FFFFF);
    send_word(16'h7FFF, 16'h7FFF, 22'd123456);
    set_geometry(22'd0, 22'd300000);     // no wheel
    send_word(16'h7FFF, 16'h8000, 22'h3FFFFF);
    send_word(16'd500, 16'd900, 22'd10000);
    set_geometry(22'd150000, 22'd0);     // no track
    send_word(16'd500, 16'd900, 22'd10000);
    send_word(16'h8000, 16'h8000, 22'h3FFFFF);
    set_geometry(22'h3FFFFF, 22'h3FFFFF); // diameter masked to its width
    send_word(16'h7FFF, 16'h7FFF, 22'h3FFFFF);
    send_word(16'h8000, 16'h7FFF, 22'h3FFFFF);

    // random phases across geometries
    set_geometry(22'd100000, 22'd300000);
    random_phase(130);
    set_geometry(22'd2000000, 22'd4000000);
    random_phase(120);
    set_geometry(22'd1000, 22'd1000);
    random_phase(120);
    set_geometry(22'($urandom_range(1000, 2000000)), 22'($urandom_range(1000, 4000000)));
    random_phase(130);
    set_geometry(22'd0, 22'($urandom_range(1000, 4000000)));
    random_phase(30);
    set_geometry(22'($urandom_range(1000, 2000000)), 22'd0);
    random_phase(40);
    set_geometry(22'($urandom), 22'($urandom));
    random_phase(110);

    // drive straight at top speed until x clamps, then back off
    set_geometry(22'h1FFFFF, 22'd0);
    calm = 1'b1;
    repeat (600) send_word(16'h7FFF, 16'h8000, 22'h3FFFFF);
    repeat (10) send_word(16'h8000, 16'h7FFF, 22'h3FFFFF);
    calm = 1'b0;

    settle();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("diff_drive_odometry_tb: PASS");
    else $display("diff_drive_odometry_tb: FAIL");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("diff_drive_odometry_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

FILE: diff_drive_odometry.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_in_if.sv
hw/rtl/ddo_out_if.sv
hw/rtl/diff_drive_odometry.sv
verif/diff_drive_odometry_chk.sv
verif/diff_drive_odometry_tb.sv
